>>> rtl/uts2c_pkg.sv
// Shared types, constants and constant-divisor helpers for the Unix time to calendar core.
package uts2c_pkg;

    // Seconds from 1970-01-01 to 2000-01-01, and the base calendar year
    localparam logic [31:0] EPOCH_2000     = 32'd946684800;
    localparam logic [11:0] BASE_YEAR      = 12'd2000;

    // Configuration register indexes and reset values
    localparam logic        CFG_YEAR_MAX   = 1'b0;
    localparam logic        CFG_YEAR_MIN   = 1'b1;
    localparam logic [11:0] YEAR_MAX_RESET = 12'd2099;
    localparam logic [11:0] YEAR_MIN_RESET = 12'd2000;

    // Day index of 2100-03-01 counted from 2000-01-01; 2100 has no Feb 29
    localparam logic [15:0] DAY_2100_MAR1  = 16'd36584;

    // Four-year cycle starting on a leap year
    localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
    localparam logic [10:0] DAYS_Y0_END    = 11'd366;
    localparam logic [10:0] DAYS_Y1_END    = 11'd731;
    localparam logic [10:0] DAYS_Y2_END    = 11'd1096;

    // Reciprocal constants (multiply then shift gives the exact quotient)
    localparam logic [31:0] RECIP_15       = 32'h88888889; // shift 35
    localparam logic [16:0] RECIP_3        = 17'd87382;    // shift 18
    localparam logic [16:0] RECIP_1461     = 17'd91868;    // shift 27
    localparam logic [16:0] RECIP_7        = 17'd74899;    // shift 19

    // Time-of-day split result handed to the date stages
    typedef struct packed {
        logic        pre2000;
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [15:0] day_count;
        logic [15:0] day_count_adj;
    } uts2c_time_t;

    // One converted result
    typedef struct packed {
        logic        status;
        logic [5:0]  second_of_minute;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_of_year;
        logic [11:0] calendar_year;
        logic [2:0]  weekday;
    } uts2c_result_t;

    // x / 60 as (x / 4) / 15
    function automatic logic [25:0] div60_32(input logic [31:0] x);
        logic [61:0] p;
        p = 62'(x[31:2]) * 62'(RECIP_15);
        return p[60:35];
    endfunction

    // x / 24 as (x / 8) / 3, valid for x below 2^20
    function automatic logic [15:0] div24_20(input logic [19:0] x);
        logic [33:0] p;
        p = 34'(x[19:3]) * 34'(RECIP_3);
        return p[33:18];
    endfunction

    // x / 1461 for day counts in range
    function automatic logic [5:0] div1461_16(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'(RECIP_1461);
        return p[32:27];
    endfunction

    // x / 7 for any 16-bit x
    function automatic logic [13:0] div7_16(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'(RECIP_7);
        return p[32:19];
    endfunction

    // Zero-based day of year on which a month starts
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m >= 4'd3)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

>>> rtl/uts2c_time_split.sv
// Five-stage pipeline: epoch check, then seconds, minutes, hours and day count.
module uts2c_time_split (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            in_ts,
    output logic                   out_valid,
    input  logic                   out_ready,
    output uts2c_pkg::uts2c_time_t out_time
);
    import uts2c_pkg::*;

    logic adv1, adv2, adv3, adv4, adv5;

    logic        s1_valid_reg, s1_pre_reg;
    logic [31:0] s1_t_reg;
    logic        s2_valid_reg, s2_pre_reg;
    logic [31:0] s2_t_reg;
    logic [25:0] s2_q1_reg, s2_q1_next;
    logic        s3_valid_reg, s3_pre_reg;
    logic [5:0]  s3_sec_reg, s3_sec_next;
    logic [25:0] s3_q1_reg;
    logic [19:0] s3_q2_reg, s3_q2_next;
    logic        s4_valid_reg, s4_pre_reg;
    logic [5:0]  s4_sec_reg, s4_min_reg, s4_min_next;
    logic [19:0] s4_q2_reg;
    logic [15:0] s4_q3_reg, s4_q3_next;
    logic        s5_valid_reg;
    uts2c_time_t s5_time_reg, s5_time_next;

    logic [31:0] sec_full;
    logic [25:0] q2_full, min_full;
    logic [19:0] hr_full;

    // Each stage advances when it is empty or the next one advances
    always_comb begin
        adv5     = !s5_valid_reg || out_ready;
        adv4     = !s4_valid_reg || adv5;
        adv3     = !s3_valid_reg || adv4;
        adv2     = !s2_valid_reg || adv3;
        adv1     = !s1_valid_reg || adv2;
        in_ready = adv1;
    end

    // Stage computations
    always_comb begin
        s2_q1_next  = div60_32(s1_t_reg);
        sec_full    = s2_t_reg - 32'(s2_q1_reg) * 32'd60;
        s3_sec_next = sec_full[5:0];
        q2_full     = div60_32({6'd0, s2_q1_reg});
        s3_q2_next  = q2_full[19:0];
        min_full    = s3_q1_reg - 26'(s3_q2_reg) * 26'd60;
        s4_min_next = min_full[5:0];
        s4_q3_next  = div24_20(s3_q2_reg);
        hr_full     = s4_q2_reg - 20'(s4_q3_reg) * 20'd24;

        s5_time_next.pre2000          = s4_pre_reg;
        s5_time_next.second_of_minute = s4_sec_reg;
        s5_time_next.minute_of_hour   = s4_min_reg;
        s5_time_next.hour_of_day      = hr_full[4:0];
        s5_time_next.day_count        = s4_q3_reg;
        // insert a virtual Feb 29 2100 so a plain every-fourth-year rule holds
        s5_time_next.day_count_adj    = s4_q3_reg +
                                        16'(s4_q3_reg >= DAY_2100_MAR1);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
            if (adv4) s4_valid_reg <= s3_valid_reg;
            if (adv5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_pre_reg <= (in_ts < EPOCH_2000);
            s1_t_reg   <= in_ts - EPOCH_2000;
        end
        if (adv2) begin
            s2_pre_reg <= s1_pre_reg;
            s2_t_reg   <= s1_t_reg;
            s2_q1_reg  <= s2_q1_next;
        end
        if (adv3) begin
            s3_pre_reg <= s2_pre_reg;
            s3_sec_reg <= s3_sec_next;
            s3_q1_reg  <= s2_q1_reg;
            s3_q2_reg  <= s3_q2_next;
        end
        if (adv4) begin
            s4_pre_reg <= s3_pre_reg;
            s4_sec_reg <= s3_sec_reg;
            s4_min_reg <= s4_min_next;
            s4_q2_reg  <= s3_q2_reg;
            s4_q3_reg  <= s4_q3_next;
        end
        if (adv5) begin
            s5_time_reg <= s5_time_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_time  = s5_time_reg;

    // Input stalls only when every stage holds an item
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg &&
                       s4_valid_reg && s5_valid_reg))
        else $error("input stalled with an empty stage");

endmodule

>>> rtl/uts2c_date.sv
// Four-stage pipeline: year, month, day of month, weekday and range check.
module uts2c_date (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  uts2c_pkg::uts2c_time_t   in_time,
    input  logic [11:0]              year_max,
    input  logic [11:0]              year_min,
    output logic                     out_valid,
    input  logic                     out_ready,
    output uts2c_pkg::uts2c_result_t out_result
);
    import uts2c_pkg::*;

    logic adv6, adv7, adv8, adv9;

    logic        s6_valid_reg, s6_pre_reg;
    logic [5:0]  s6_sec_reg, s6_min_reg;
    logic [4:0]  s6_hr_reg;
    logic [15:0] s6_days5_reg, s6_days5_next, s6_dadj_reg;
    logic [5:0]  s6_q4_reg, s6_q4_next;
    logic [13:0] s6_wq_reg, s6_wq_next;

    logic        s7_valid_reg, s7_pre_reg;
    logic [5:0]  s7_sec_reg, s7_min_reg;
    logic [4:0]  s7_hr_reg;
    logic [5:0]  s7_q4_reg;
    logic [10:0] s7_rem_reg, s7_rem_next;
    logic [2:0]  s7_wd_reg, s7_wd_next;

    logic        s8_valid_reg, s8_status_reg, s8_status_next;
    logic [5:0]  s8_sec_reg, s8_min_reg;
    logic [4:0]  s8_hr_reg;
    logic [2:0]  s8_wd_reg;
    logic [11:0] s8_year_reg, s8_year_next;
    logic        s8_leap_reg, s8_leap_next;
    logic [8:0]  s8_doy_reg, s8_doy_next;

    logic        s9_valid_reg, s9_status_reg;
    logic [5:0]  s9_sec_reg, s9_min_reg;
    logic [4:0]  s9_hr_reg;
    logic [2:0]  s9_wd_reg;
    logic [11:0] s9_year_reg;
    logic [3:0]  s9_month_reg, s9_month_next;
    logic [8:0]  s9_start_reg, s9_start_next;
    logic [8:0]  s9_doy_reg;

    logic [15:0] rem_full, wd_full;
    logic [10:0] doy_off;
    logic [1:0]  year_in_quad;
    logic [8:0]  day_full;

    // Each stage advances when it is empty or the next one advances
    always_comb begin
        adv9     = !s9_valid_reg || out_ready;
        adv8     = !s8_valid_reg || adv9;
        adv7     = !s7_valid_reg || adv8;
        adv6     = !s6_valid_reg || adv7;
        in_ready = adv6;
    end

    // Quotients for the four-year cycle and the weekday
    always_comb begin
        // 2000-01-01 was a Saturday
        s6_days5_next = in_time.day_count + 16'd5;
        s6_q4_next    = div1461_16(in_time.day_count_adj);
        s6_wq_next    = div7_16(s6_days5_next);
    end

    // Remainders
    always_comb begin
        rem_full    = s6_dadj_reg - 16'(s6_q4_reg) * 16'(DAYS_PER_QUAD);
        s7_rem_next = rem_full[10:0];
        wd_full     = s6_days5_reg - 16'(s6_wq_reg) * 16'd7;
        s7_wd_next  = wd_full[2:0] + 3'd1;
    end

    // Year within the four-year cycle, day of year, range check
    always_comb begin
        if (s7_rem_reg < DAYS_Y0_END) begin
            year_in_quad = 2'd0;
            doy_off      = s7_rem_reg;
        end else if (s7_rem_reg < DAYS_Y1_END) begin
            year_in_quad = 2'd1;
            doy_off      = s7_rem_reg - DAYS_Y0_END;
        end else if (s7_rem_reg < DAYS_Y2_END) begin
            year_in_quad = 2'd2;
            doy_off      = s7_rem_reg - DAYS_Y1_END;
        end else begin
            year_in_quad = 2'd3;
            doy_off      = s7_rem_reg - DAYS_Y2_END;
        end
        s8_doy_next    = doy_off[8:0];
        s8_leap_next   = (year_in_quad == 2'd0);
        s8_year_next   = BASE_YEAR + 12'({s7_q4_reg, 2'b00}) + 12'(year_in_quad);
        s8_status_next = s7_pre_reg || (s8_year_next > year_max) ||
                         (s8_year_next < year_min);
    end

    // Month: last month whose start is not past the day of year
    always_comb begin
        s9_month_next = 4'd1;
        s9_start_next = 9'd0;
        for (int mi = 2; mi <= 12; mi++) begin
            if (s8_doy_reg >= month_start(4'(mi), s8_leap_reg)) begin
                s9_month_next = 4'(mi);
                s9_start_next = month_start(4'(mi), s8_leap_reg);
            end
        end
    end

    // Day of month and result; an invalid result carries zero fields
    always_comb begin
        day_full = s9_doy_reg - s9_start_reg + 9'd1;
        if (s9_status_reg) begin
            out_result        = '0;
            out_result.status = 1'b1;
        end else begin
            out_result.status           = 1'b0;
            out_result.second_of_minute = s9_sec_reg;
            out_result.minute_of_hour   = s9_min_reg;
            out_result.hour_of_day      = s9_hr_reg;
            out_result.day_of_month     = day_full[4:0];
            out_result.month_of_year    = s9_month_reg;
            out_result.calendar_year    = s9_year_reg;
            out_result.weekday          = s9_wd_reg;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end else begin
            if (adv6) s6_valid_reg <= in_valid;
            if (adv7) s7_valid_reg <= s6_valid_reg;
            if (adv8) s8_valid_reg <= s7_valid_reg;
            if (adv9) s9_valid_reg <= s8_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (adv6) begin
            s6_pre_reg   <= in_time.pre2000;
            s6_sec_reg   <= in_time.second_of_minute;
            s6_min_reg   <= in_time.minute_of_hour;
            s6_hr_reg    <= in_time.hour_of_day;
            s6_days5_reg <= s6_days5_next;
            s6_dadj_reg  <= in_time.day_count_adj;
            s6_q4_reg    <= s6_q4_next;
            s6_wq_reg    <= s6_wq_next;
        end
        if (adv7) begin
            s7_pre_reg <= s6_pre_reg;
            s7_sec_reg <= s6_sec_reg;
            s7_min_reg <= s6_min_reg;
            s7_hr_reg  <= s6_hr_reg;
            s7_q4_reg  <= s6_q4_reg;
            s7_rem_reg <= s7_rem_next;
            s7_wd_reg  <= s7_wd_next;
        end
        if (adv8) begin
            s8_status_reg <= s8_status_next;
            s8_sec_reg    <= s7_sec_reg;
            s8_min_reg    <= s7_min_reg;
            s8_hr_reg     <= s7_hr_reg;
            s8_wd_reg     <= s7_wd_reg;
            s8_year_reg   <= s8_year_next;
            s8_leap_reg   <= s8_leap_next;
            s8_doy_reg    <= s8_doy_next;
        end
        if (adv9) begin
            s9_status_reg <= s8_status_reg;
            s9_sec_reg    <= s8_sec_reg;
            s9_min_reg    <= s8_min_reg;
            s9_hr_reg     <= s8_hr_reg;
            s9_wd_reg     <= s8_wd_reg;
            s9_year_reg   <= s8_year_reg;
            s9_month_reg  <= s9_month_next;
            s9_start_reg  <= s9_start_next;
            s9_doy_reg    <= s8_doy_reg;
        end
    end

    assign out_valid = s9_valid_reg;

endmodule

>>> rtl/unix_seconds_to_calendar_core.sv
// Top level: Unix seconds to Gregorian date, time and weekday, stream in and out.
// Nine pipeline stages plus the output register lie between an input transaction and
// its result; one transaction per cycle sustained while m_tready stays high.
// Stalls back up stage by stage; bubbles are squeezed out, so input is taken while
// a result waits. Synchronous active-low reset clears valid bits and sets year limits.
module unix_seconds_to_calendar_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] unix_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [5:0] second_of_minute, [11:6] minute_of_hour,
                                   // [16:12] hour_of_day, [21:17] day_of_month,
                                   // [25:22] month_of_year, [37:26] calendar_year,
                                   // [40:38] weekday, [47:41] zero
    output logic        m_tuser,   // [0] status
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata
);
    import uts2c_pkg::*;

    logic          split_valid, split_ready;
    uts2c_time_t   split_time;
    logic          date_valid, date_ready;
    uts2c_result_t date_result;

    logic [11:0]   year_max_reg, year_min_reg;
    logic          m_valid_reg;
    logic [47:0]   m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_max_reg <= YEAR_MAX_RESET;
            year_min_reg <= YEAR_MIN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_YEAR_MAX: year_max_reg <= cfg_wdata;
                CFG_YEAR_MIN: year_min_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    uts2c_time_split u_time_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_ts     (s_tdata),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_time  (split_time)
    );

    uts2c_date u_date (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (split_valid),
        .in_ready   (split_ready),
        .in_time    (split_time),
        .year_max   (year_max_reg),
        .year_min   (year_min_reg),
        .out_valid  (date_valid),
        .out_ready  (date_ready),
        .out_result (date_result)
    );

    // Pack the result fields, lowest field first
    assign m_tdata_next = {7'd0,
                           date_result.weekday,
                           date_result.calendar_year,
                           date_result.month_of_year,
                           date_result.day_of_month,
                           date_result.hour_of_day,
                           date_result.minute_of_hour,
                           date_result.second_of_minute};

    // Output register: load when empty or when the held transaction is taken
    assign date_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (date_ready) begin
            m_valid_reg <= date_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (date_ready) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= date_result.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Invalid results carry no date or time
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 48'd0))
        else $error("invalid result with nonzero fields");

    // Valid results have a legal time of day
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> ((m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) &&
                                    (m_tdata[16:12] < 5'd24)))
        else $error("time of day out of range");

    // Valid results have a legal date and weekday
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> ((m_tdata[21:17] != 5'd0) && (m_tdata[25:22] != 4'd0) &&
                                    (m_tdata[25:22] < 4'd13) && (m_tdata[40:38] != 3'd0) &&
                                    (m_tdata[47:41] == 7'd0)))
        else $error("date or weekday out of range");

endmodule

>>> tb/unix_seconds_to_calendar_core_tb.sv
// Self-checking testbench for the Unix seconds to calendar date core.
`timescale 1ns / 100ps

module unix_seconds_to_calendar_core_tb;
    import uts2c_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned LONG_HOLD    = 90;
    localparam int unsigned SECS_PER_DAY = 86400;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE
    } ready_mode_t;

    // Expected result paired with the timestamp that produced it
    typedef struct {
        logic [31:0]   ts;
        uts2c_result_t cal;
    } calendar_entry_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [11:0] cfg_wdata = '0;

    // Local copy of the year limits
    logic [11:0] year_max_cfg = YEAR_MAX_RESET;
    logic [11:0] year_min_cfg = YEAR_MIN_RESET;

    logic [31:0]     pending_ts[$];
    calendar_entry_t pending_dates[$];

    int unsigned gap_max       = 6;
    int unsigned gap_left      = 0;
    int unsigned burst_left    = 0;
    bit          long_hold_req = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned mode_left     = 0;
    ready_mode_t ready_mode    = RDY_ALWAYS;
    int unsigned cycle_cnt     = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned valid_cnt     = 0;
    int unsigned reject_cnt    = 0;
    int unsigned setting_cnt   = 1;

    unix_seconds_to_calendar_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned days_in_year(input int unsigned y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        return leap ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            2:            len = (days_in_year(y) == 366) ? 29 : 28;
            4, 6, 9, 11:  len = 30;
            default:      len = 31;
        endcase
        return len;
    endfunction

    // Convert one timestamp under the given year window
    function automatic uts2c_result_t unix_to_calendar(input logic [31:0] ts,
            input logic [11:0] ymax, input logic [11:0] ymin);
        uts2c_result_t res;
        int unsigned   rem;
        int unsigned   days;
        int unsigned   sec;
        int unsigned   mnt;
        int unsigned   hr;
        int unsigned   yr;
        int unsigned   mon;
        res        = '0;
        res.status = 1'b1;
        if (ts < EPOCH_2000) begin
            return res;
        end
        rem  = ts - EPOCH_2000;
        sec  = rem % 60;
        rem  = rem / 60;
        mnt  = rem % 60;
        rem  = rem / 60;
        hr   = rem % 24;
        days = rem / 24;
        // Strip whole years, stopping once the window is passed
        rem = days;
        yr  = BASE_YEAR;
        while (yr <= ymax && rem >= days_in_year(yr)) begin
            rem = rem - days_in_year(yr);
            yr++;
        end
        if (yr > ymax || yr < ymin) begin
            return res;
        end
        mon = 1;
        while (mon < 12 && rem >= month_length(yr, mon)) begin
            rem = rem - month_length(yr, mon);
            mon++;
        end
        res.status           = 1'b0;
        res.second_of_minute = 6'(sec);
        res.minute_of_hour   = 6'(mnt);
        res.hour_of_day      = 5'(hr);
        res.day_of_month     = 5'(rem + 1);
        res.month_of_year    = 4'(mon);
        res.calendar_year    = 12'(yr);
        // 2000-01-01 fell on a Saturday
        res.weekday          = 3'((days + 5) % 7 + 1);
        return res;
    endfunction

    // Timestamp within about a day of the start of a month
    function automatic logic [31:0] near_month_start(input int unsigned y, input int unsigned m);
        longint      secs;
        int unsigned yy;
        int unsigned mm;
        secs = EPOCH_2000;
        for (yy = BASE_YEAR; yy < y; yy++) begin
            secs = secs + SECS_PER_DAY * days_in_year(yy);
        end
        for (mm = 1; mm < m; mm++) begin
            secs = secs + SECS_PER_DAY * month_length(y, mm);
        end
        secs = secs + longint'($urandom_range(0, 180000)) - 90000;
        if (secs > 64'hFFFF_FFFF) begin
            secs = 64'hFFFF_FFFF - $urandom_range(0, 3 * SECS_PER_DAY);
        end
        return secs[31:0];
    endfunction

    // Mix of full-range noise, pre-2000 values, boundary cases and in-range values
    function automatic logic [31:0] random_timestamp();
        int unsigned pick;
        int unsigned y;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return $urandom;
        end
        if (pick < 15) begin
            return EPOCH_2000 - $urandom_range(1, 100000);
        end
        if (pick < 55) begin
            if (year_min_cfg <= year_max_cfg && $urandom_range(0, 1) == 1) begin
                y = $urandom_range(year_min_cfg, year_max_cfg);
            end else begin
                y = $urandom_range(2000, 2106);
            end
            return near_month_start(y, $urandom_range(1, 12));
        end
        return $urandom_range(EPOCH_2000, 32'hFFFF_FFFF);
    endfunction

    task automatic check_field(input logic [31:0] ts, input string name,
            input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 60) begin
                $display("%0t: ts %0d %s mismatch, expected %0d, actual %0d",
                         $time, ts, name, want, got);
            end
        end
    endtask

    // Wait until every offered item is accepted and every result has come back
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_ts.size() != 0 || s_tvalid || pending_dates.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [11:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        if (addr == CFG_YEAR_MAX) begin
            year_max_cfg = val;
        end else begin
            year_min_cfg = val;
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_year_window(input logic [11:0] ymax, input logic [11:0] ymin);
        wait_drained();
        write_reg(CFG_YEAR_MAX, ymax);
        write_reg(CFG_YEAR_MIN, ymin);
        @(negedge aclk);
        setting_cnt++;
    endtask

    task automatic run_random_phase(input logic [11:0] ymax, input logic [11:0] ymin,
            input int unsigned count, input int unsigned gmax, input bit squeeze);
        set_year_window(ymax, ymin);
        gap_max = gmax;
        repeat (count) pending_ts.push_back(random_timestamp());
        // Let the receiver hold off while the sender keeps offering
        if (squeeze) begin
            long_hold_req = 1'b1;
        end
    endtask

    // Offer queued timestamps in bursts; record the prediction on each transaction
    always @(posedge aclk) begin : drive_proc
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                pending_dates.push_back('{ts: s_tdata,
                    cal: unix_to_calendar(s_tdata, year_max_cfg, year_min_cfg)});
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ts.size() > 0) begin
                    s_tdata    <= pending_ts.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        if (gap_max == 0 || $urandom_range(0, 3) == 0) begin
                            gap_left = 0;
                        end else begin
                            gap_left = $urandom_range(1, gap_max);
                        end
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Drive m_tready: a long hold when asked, otherwise a changing stall pattern
    always @(posedge aclk) begin : ready_proc
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = ready_mode_t'($urandom_range(0, 2));
                    mode_left  = $urandom_range(10, 60);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    default:    m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check_proc
        calendar_entry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dates.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected result, expected none, actual status %0b data %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_dates.pop_front();
                check_field(want.ts, "status", want.cal.status, m_tuser);
                check_field(want.ts, "second", want.cal.second_of_minute, m_tdata[5:0]);
                check_field(want.ts, "minute", want.cal.minute_of_hour, m_tdata[11:6]);
                check_field(want.ts, "hour", want.cal.hour_of_day, m_tdata[16:12]);
                check_field(want.ts, "day", want.cal.day_of_month, m_tdata[21:17]);
                check_field(want.ts, "month", want.cal.month_of_year, m_tdata[25:22]);
                check_field(want.ts, "year", want.cal.calendar_year, m_tdata[37:26]);
                check_field(want.ts, "weekday", want.cal.weekday, m_tdata[40:38]);
                check_field(want.ts, "padding", 0, m_tdata[47:41]);
                if (want.cal.status) begin
                    reject_cnt++;
                end else begin
                    valid_cnt++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin : watchdog_proc
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stim_proc
        logic [11:0] ymin;
        logic [11:0] ymax;
        int unsigned k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset window: epoch edge, time-of-day rollovers, leap day, 2038, top of range
        pending_ts = '{32'd0, 32'd946684799, 32'd946684800, 32'd946684859,
                       32'd946688399, 32'd946771199, 32'd951782400, 32'd951868800,
                       32'd978220800, 32'd978307200, 32'd1709164800, 32'd2147483647,
                       32'd2147483648, 32'd4102444799, 32'd4102444800, 32'hFFFF_FFFF};

        // Widest window: 2100 without Feb 29, last full year, largest timestamp
        set_year_window(12'd2106, 12'd2000);
        pending_ts = '{32'd4102444800, 32'd4107455999, 32'd4107542400, 32'd4291747199,
                       32'd4291747200, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};

        run_random_phase(12'd2106, 12'd2000, 105, 0, 1'b1);
        run_random_phase(12'd2000, 12'd2000, 105, 6, 1'b0);
        run_random_phase(12'd2106, 12'd2106, 105, 6, 1'b0);
        // Minimum above maximum rejects everything
        run_random_phase(12'd2040, 12'd2050, 100, 4, 1'b0);
        for (k = 0; k < 3; k++) begin
            ymin = 12'($urandom_range(2000, 2106));
            ymax = 12'($urandom_range(ymin, 2106));
            run_random_phase(ymax, ymin, 105, 3 + 4 * k, 1'b0);
        end
        run_random_phase(YEAR_MAX_RESET, YEAR_MIN_RESET, 105, 6, 1'b0);
        run_random_phase(12'd2106, 12'd2000, 105, 12, 1'b0);

        wait_drained();
        if (pending_dates.size() != 0) begin
            mismatch_cnt++;
            $display("%0t: %0d results never arrived", $time, pending_dates.size());
        end
        $display("Converted %0d timestamps: %0d dates, %0d rejected, over %0d year windows.",
                 valid_cnt + reject_cnt, valid_cnt, reject_cnt, setting_cnt);
        $display("Field mismatches: %0d, cycles: %0d", mismatch_cnt, cycle_cnt);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
